// ===== design/heartbeat_liveness_monitor_macros.svh =====
// Assertion macros for the heartbeat liveness monitor.
// Users supply clk and rst in the enclosing scope; no other dependencies.
`ifndef HEARTBEAT_LIVENESS_MONITOR_MACROS_SVH
`define HEARTBEAT_LIVENESS_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define HLM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define HLM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hlm_pkg.sv =====
// Shared types and constants for the heartbeat liveness monitor.
// No dependencies; used by the interfaces, the serial units and the top level.
package hlm_pkg;

  localparam int TIME_WIDTH_DEF = 48;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] DEAD_TIME_RST = 32'd3000;
  localparam logic [CFG_W-1:0] KEEPALIVE_RST = 32'd1000;

  // Item commands
  localparam logic CMD_CHECK      = 1'b0;
  localparam logic CMD_REACTIVATE = 1'b1;

  // Status of the bit-serial time unit
  typedef struct packed {
    logic              busy;
    logic              lt;       // now is before the deadline
    logic [CFG_W-1:0]  remain;   // deadline - now, saturated to 32 bits
  } alu_stat_t;

  // Status of the budget divider
  typedef struct packed {
    logic              busy;
    logic [CFG_W-1:0]  budget;   // retry budget to load
  } div_stat_t;

endpackage

// ===== design/hlm_if.sv =====
// Valid/ready channel interfaces for the heartbeat liveness monitor.
// Depends on hlm_pkg for the default time width.
interface hlm_in_if #(
  parameter int TIME_WIDTH = hlm_pkg::TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [TIME_WIDTH-1:0] now_ms;

  modport source (output valid, cmd, now_ms, input ready);
  modport sink   (input valid, cmd, now_ms, output ready);
endinterface

interface hlm_out_if;
  logic        valid;
  logic        ready;
  logic        alive;
  logic        send_heartbeat;
  logic [31:0] remaining_ms;
  logic [31:0] retries_left;

  modport source (output valid, alive, send_heartbeat, remaining_ms, retries_left,
                  input ready);
  modport sink   (input valid, alive, send_heartbeat, remaining_ms, retries_left,
                  output ready);
endinterface

// ===== design/hlm_divider.sv =====
// Radix-2 restoring divider that derives the retry budget from the dead time
// and keepalive period, one quotient bit per cycle. Depends on hlm_pkg.
module hlm_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hlm_pkg::CFG_W-1:0] dividend,
  input  logic [hlm_pkg::CFG_W-1:0] divisor,
  output hlm_pkg::div_stat_t        stat
);

  localparam int W     = hlm_pkg::CFG_W;
  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;

  logic [W:0]       rem_shift;
  logic [W:0]       trial;
  logic             ge;

  // One trial subtraction per cycle
  assign rem_shift = {rem, quo[W-1]};
  assign trial     = rem_shift - {1'b0, dvs};
  assign ge        = ~trial[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quo <= {quo[W-2:0], ge};
      rem <= ge ? trial[W-1:0] : rem_shift[W-1:0];
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Budget: quotient, less one on an exact division, held at zero;
  // a zero keepalive loads zero
  always_comb begin
    stat.busy = busy;
    if (dvs == '0) begin
      stat.budget = '0;
    end else if (rem == '0) begin
      stat.budget = (quo == '0) ? '0 : quo - 1'b1;
    end else begin
      stat.budget = quo;
    end
  end

endmodule

// ===== design/hlm_serial_alu.sv =====
// Bit-serial time unit: in one LSB-first pass it forms deadline - now (for
// the compare and remaining time) and now + keepalive (the new deadline).
// Depends on hlm_pkg.
module hlm_serial_alu #(
  parameter int TIME_WIDTH = hlm_pkg::TIME_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [TIME_WIDTH-1:0]     now,
  input  logic [TIME_WIDTH:0]       deadline,
  input  logic [hlm_pkg::CFG_W-1:0] keepalive,
  output hlm_pkg::alu_stat_t        stat,
  output logic [TIME_WIDTH:0]       sum
);

  localparam int N     = TIME_WIDTH + 1;
  localparam int RW    = hlm_pkg::CFG_W;
  localparam int CNT_W = $clog2(N);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [N-1:0]     a_sh;
  logic [N-1:0]     n_sh;
  logic [N-1:0]     k_sh;
  logic [N-1:0]     sum_sh;
  logic [RW-1:0]    diff_lo;
  logic             borrow;
  logic             carry;
  logic             nz;
  logic             hi_nz;

  logic a_bit, n_bit, k_bit;
  logic d_bit, s_bit;
  logic borrow_next, carry_next;
  logic hi;

  assign a_bit = a_sh[0];
  assign n_bit = n_sh[0];
  assign k_bit = k_sh[0];

  // Full subtractor and full adder on the current bit
  assign d_bit       = a_bit ^ n_bit ^ borrow;
  assign borrow_next = (~a_bit & n_bit) | (~a_bit & borrow) | (n_bit & borrow);
  assign s_bit       = n_bit ^ k_bit ^ carry;
  assign carry_next  = (n_bit & k_bit) | (n_bit & carry) | (k_bit & carry);
  assign hi          = (cnt >= CNT_W'(RW));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      cnt     <= '0;
      a_sh    <= deadline;
      n_sh    <= {1'b0, now};
      k_sh    <= {{(N - RW){1'b0}}, keepalive};
      borrow  <= 1'b0;
      carry   <= 1'b0;
      nz      <= 1'b0;
      hi_nz   <= 1'b0;
      diff_lo <= '0;
    end else if (busy) begin
      a_sh   <= a_sh >> 1;
      n_sh   <= n_sh >> 1;
      k_sh   <= k_sh >> 1;
      sum_sh <= {s_bit, sum_sh[N-1:1]};
      borrow <= borrow_next;
      carry  <= carry_next;
      nz     <= nz | d_bit;
      // low 32 bits of the difference collect; any higher one saturates
      if (hi) begin
        hi_nz <= hi_nz | d_bit;
      end else begin
        diff_lo <= {d_bit, diff_lo[RW-1:1]};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(N - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy   = busy;
  assign stat.lt     = ~borrow & nz;
  assign stat.remain = hi_nz ? {RW{1'b1}} : diff_lo;
  assign sum         = sum_sh;

endmodule

// ===== design/heartbeat_liveness_monitor.sv =====
// Heartbeat liveness monitor top level: config registers, watchdog state,
// control sequencer and output register.
// Depends on hlm_pkg, hlm_if, hlm_divider, hlm_serial_alu and the macro header.
//
//   channel  | role   | contents
//   ---------+--------+-----------------------------------------------------
//   in_ch    | sink   | cmd, now_ms
//   out_ch   | source | alive, send_heartbeat, remaining_ms, retries_left
//   cfg      | write  | cfg_we, cfg_idx, cfg_data (dead time, keepalive)
//
// Each item holds the input until its bit-serial pass over the deadline is
// done (the budget divider runs alongside it) and its result is registered.
// Reset (rst, synchronous) loads the config defaults and zeroes deadline and
// budget, so checks report dead until the first reactivate.
// A stalled output holds its result; the next item is taken meanwhile and
// waits at the end of its pass until the output register frees.
`include "heartbeat_liveness_monitor_macros.svh"

module heartbeat_liveness_monitor #(
  parameter int TIME_WIDTH = hlm_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  hlm_in_if.sink                        in_ch,
  hlm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [hlm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hlm_pkg::CFG_W-1:0]     cfg_data
);

  localparam int W = hlm_pkg::CFG_W;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  state_t              state;
  logic [W-1:0]        dead_time;
  logic [W-1:0]        keepalive;
  logic [TIME_WIDTH:0] deadline;
  logic [W-1:0]        budget;
  logic                cmd_q;

  logic                out_valid;
  logic                alive;
  logic                send_hb;
  logic [W-1:0]        remain;
  logic [W-1:0]        retries;

  hlm_pkg::alu_stat_t  alu_stat;
  hlm_pkg::div_stat_t  div_stat;
  logic [TIME_WIDTH:0] alu_sum;

  logic accept;
  logic finish;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign finish      = (state == S_WORK) && !alu_stat.busy && !div_stat.busy &&
                       (!out_valid || out_ch.ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_time <= hlm_pkg::DEAD_TIME_RST;
      keepalive <= hlm_pkg::KEEPALIVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hlm_pkg::REG_DEAD_TIME: dead_time <= cfg_data;
        hlm_pkg::REG_KEEPALIVE: keepalive <= cfg_data;
        default: ;
      endcase
    end
  end

  hlm_serial_alu #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_alu (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .now       (in_ch.now_ms),
    .deadline  (deadline),
    .keepalive (keepalive),
    .stat      (alu_stat),
    .sum       (alu_sum)
  );

  hlm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (dead_time),
    .divisor  (keepalive),
    .stat     (div_stat)
  );

  // Sequencer, watchdog state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      deadline  <= '0;
      budget    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !finish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= in_ch.cmd;
            state <= S_WORK;
          end
        end
        S_WORK: begin
          if (finish) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (cmd_q == hlm_pkg::CMD_REACTIVATE) begin
              // reload budget, re-arm: deadline - now is the keepalive
              budget   <= div_stat.budget;
              deadline <= alu_sum;
              alive    <= 1'b1;
              send_hb  <= 1'b0;
              remain   <= keepalive;
              retries  <= div_stat.budget;
            end else if (alu_stat.lt) begin
              alive   <= 1'b1;
              send_hb <= 1'b0;
              remain  <= alu_stat.remain;
              retries <= budget;
            end else if (budget != '0) begin
              // deadline passed: spend one retry and re-arm
              budget   <= budget - 1'b1;
              deadline <= alu_sum;
              alive    <= 1'b1;
              send_hb  <= 1'b1;
              remain   <= keepalive;
              retries  <= budget - 1'b1;
            end else begin
              alive   <= 1'b0;
              send_hb <= 1'b0;
              remain  <= '0;
              retries <= budget;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.alive          = alive;
  assign out_ch.send_heartbeat = send_hb;
  assign out_ch.remaining_ms   = remain;
  assign out_ch.retries_left   = retries;

  // Checks
  `HLM_ASSERT_IMPL(a_alu_only_in_work, alu_stat.busy, state == S_WORK, "serial unit busy outside work")
  `HLM_ASSERT_IMPL(a_send_implies_alive, out_ch.valid && out_ch.send_heartbeat, out_ch.alive, "heartbeat request on a dead peer")
  `HLM_ASSERT_NEXT(a_div_on_reactivate, accept && in_ch.cmd == hlm_pkg::CMD_REACTIVATE, div_stat.busy, "budget divider not started")

endmodule

// ===== sim/heartbeat_liveness_monitor_tb.sv =====
// Self-checking testbench for the heartbeat liveness monitor: a directed table
// and randomized watchdog sequences, scored by a local predictor or listed results.
// Depends on hlm_pkg, hlm_if and the heartbeat_liveness_monitor RTL.
module heartbeat_liveness_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hlm_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;
  localparam logic [TW-1:0] T_MAX = '1;

  typedef logic [TW:0] stamp_t;

  typedef struct packed {
    logic        alive;
    logic        send_heartbeat;
    logic [31:0] remaining_ms;
    logic [31:0] retries_left;
  } beat_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
    logic                  cmd;
    logic [TW-1:0]         now;
    bit                    known;
    beat_t                 want;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  hlm_in_if #(.TIME_WIDTH(TW)) in_ch ();
  hlm_out_if                   out_ch ();

  heartbeat_liveness_monitor #(.TIME_WIDTH(TW)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow registers and watchdog state
  logic [CFG_W-1:0] dead_q;
  logic [CFG_W-1:0] keep_q;
  stamp_t           deadline_q;
  logic [31:0]      budget_q;

  beat_t       pending_beats[$];
  step_row_t   plan[$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned src_idle_pct = 19;
  int unsigned sink_idle_pct = 52;
  bit          sink_hold    = 1'b0;
  bit          long_hold_go = 1'b0;
  bit          drv_known;
  beat_t       drv_want;

  // Retry budget: dead / keepalive, one less on exact division, floored at 0
  function automatic logic [31:0] retry_allowance(logic [31:0] dead, logic [31:0] keep);
    logic [31:0] q;
    if (keep == '0) return '0;
    q = dead / keep;
    if ((dead % keep) == '0) return (q == '0) ? '0 : q - 1;
    return q;
  endfunction

  // Advance the watchdog by one item and return the result it reports
  function beat_t watchdog_step(logic cmd, logic [TW-1:0] now);
    stamp_t now_x;
    stamp_t gap;
    beat_t  r;
    now_x = stamp_t'(now);
    r = '0;
    if (cmd == CMD_REACTIVATE) begin
      budget_q   = retry_allowance(dead_q, keep_q);
      deadline_q = now_x + stamp_t'(keep_q);
      r.alive    = 1'b1;
    end else if (now_x < deadline_q) begin
      r.alive = 1'b1;
    end else if (budget_q != '0) begin
      budget_q         = budget_q - 1;
      deadline_q       = now_x + stamp_t'(keep_q);
      r.send_heartbeat = 1'b1;
      r.alive          = 1'b1;
    end
    if (now_x < deadline_q) begin
      gap = deadline_q - now_x;
      // time running backwards can leave more than 32 bits to go
      r.remaining_ms = (gap > stamp_t'(32'hFFFF_FFFF)) ? '1 : gap[31:0];
    end
    r.retries_left = budget_q;
    return r;
  endfunction

  // Track register writes and predict each accepted item
  always @(posedge clk) begin
    beat_t guess;
    if (rst) begin
      dead_q     = DEAD_TIME_RST;
      keep_q     = KEEPALIVE_RST;
      deadline_q = '0;
      budget_q   = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DEAD_TIME: dead_q = cfg_data;
          REG_KEEPALIVE: keep_q = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        guess = watchdog_step(in_ch.cmd, in_ch.now_ms);
        pending_beats.push_back(drv_known ? drv_want : guess);
      end
    end
  end

  task automatic flag_field(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
               what, results_seen, want, got);
  endtask

  // Score each accepted result against the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        want = pending_beats.pop_front();
        if (out_ch.alive !== want.alive)
          flag_field("alive", 32'(want.alive), 32'(out_ch.alive));
        if (out_ch.send_heartbeat !== want.send_heartbeat)
          flag_field("send_heartbeat", 32'(want.send_heartbeat), 32'(out_ch.send_heartbeat));
        if (out_ch.remaining_ms !== want.remaining_ms)
          flag_field("remaining_ms", want.remaining_ms, out_ch.remaining_ms);
        if (out_ch.retries_left !== want.retries_left)
          flag_field("retries_left", want.retries_left, out_ch.retries_left);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off
  always @(posedge clk) begin
    out_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    wait (long_hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Present one item, with random gaps ahead of it, and wait for its accept
  task automatic offer(logic cmd, logic [TW-1:0] now, bit known, beat_t want);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.now_ms <= now;
    drv_known    <= known;
    drv_want     <= want;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stop offering until every result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_item(logic cmd, logic [TW-1:0] now);
    plan.push_back('{ROW_ITEM, REG_DEAD_TIME, '0, cmd, now, 1'b0, '0});
  endfunction

  function automatic void add_known(logic cmd, logic [TW-1:0] now, logic a, logic s,
                                    logic [31:0] rem, logic [31:0] ret);
    plan.push_back('{ROW_ITEM, REG_DEAD_TIME, '0, cmd, now, 1'b1, '{a, s, rem, ret}});
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    plan.push_back('{ROW_REG, idx, val, CMD_CHECK, '0, 1'b0, '0});
  endfunction

  initial begin
    logic [CFG_W-1:0] dead;
    logic [CFG_W-1:0] ka;
    logic [TW-1:0]    t;
    logic             cmd;
    int unsigned      pick;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_DEAD_TIME;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_CHECK;
    in_ch.now_ms <= '0;
    drv_known    <= 1'b0;
    drv_want     <= '0;

    // Directed table; defaults give a budget of 2 and a 1000 ms period
    add_known(CMD_CHECK, '0, 1'b0, 1'b0, 0, 0);               // dead out of reset
    add_known(CMD_CHECK, T_MAX, 1'b0, 1'b0, 0, 0);
    add_known(CMD_REACTIVATE, '0, 1'b1, 1'b0, 1000, 2);
    add_known(CMD_CHECK, 48'd999, 1'b1, 1'b0, 1, 2);
    add_known(CMD_CHECK, 48'd1000, 1'b1, 1'b1, 1000, 1);      // deadline hit, retry used
    add_known(CMD_CHECK, 48'd2500, 1'b1, 1'b1, 1000, 0);
    add_known(CMD_CHECK, 48'd3500, 1'b0, 1'b0, 0, 0);         // budget gone
    add_known(CMD_REACTIVATE, T_MAX, 1'b1, 1'b0, 1000, 2);    // deadline past 48 bits
    add_known(CMD_CHECK, '0, 1'b1, 1'b0, 32'hFFFF_FFFF, 2);   // time ran backwards
    add_known(CMD_CHECK, T_MAX, 1'b1, 1'b0, 1000, 2);
    add_item(CMD_CHECK, 48'h5555_5555_5555);
    add_item(CMD_CHECK, 48'hAAAA_AAAA_AAAA);
    // largest registers
    add_reg(REG_DEAD_TIME, '1);
    add_reg(REG_KEEPALIVE, '1);
    add_known(CMD_REACTIVATE, T_MAX, 1'b1, 1'b0, 32'hFFFF_FFFF, 0);
    add_known(CMD_CHECK, T_MAX, 1'b1, 1'b0, 32'hFFFF_FFFF, 0);
    // zero keepalive: deadline lands on now
    add_reg(REG_DEAD_TIME, '0);
    add_reg(REG_KEEPALIVE, '0);
    add_known(CMD_REACTIVATE, 48'd5, 1'b1, 1'b0, 0, 0);
    add_known(CMD_CHECK, 48'd5, 1'b0, 1'b0, 0, 0);
    add_reg(REG_KEEPALIVE, 32'd1);
    add_known(CMD_REACTIVATE, 48'd10, 1'b1, 1'b0, 1, 0);
    // inexact division keeps the full quotient
    add_reg(REG_DEAD_TIME, 32'd7);
    add_reg(REG_KEEPALIVE, 32'd2);
    add_known(CMD_REACTIVATE, 48'd100, 1'b1, 1'b0, 2, 3);
    add_known(CMD_CHECK, 48'd102, 1'b1, 1'b1, 2, 2);
    add_reg(REG_DEAD_TIME, '1);
    add_reg(REG_KEEPALIVE, 32'd1);
    add_known(CMD_REACTIVATE, '0, 1'b1, 1'b0, 1, 32'hFFFF_FFFE);
    add_reg(REG_DEAD_TIME, 32'd1);
    add_reg(REG_KEEPALIVE, '1);
    add_known(CMD_REACTIVATE, '0, 1'b1, 1'b0, 32'hFFFF_FFFF, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer(plan[i].cmd, plan[i].now, plan[i].known, plan[i].want);
      end
    end

    // Random watchdog sequences, one register setting per phase
    for (int phase = 0; phase < 21; phase++) begin
      case (phase / 7)
        0: begin src_idle_pct = 19; sink_idle_pct = 52; end
        1: begin src_idle_pct = 52; sink_idle_pct = 19; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      settle();
      case ($urandom_range(9))
        0: begin dead = $urandom; ka = $urandom; end
        1: begin
          dead = $urandom_range(1) ? '1 : '0;
          ka   = $urandom_range(1) ? '1 : 32'd1;
        end
        2: begin dead = $urandom_range(0, 300); ka = '0; end
        default: begin ka = $urandom_range(1, 50); dead = $urandom_range(0, 8 * ka); end
      endcase
      write_reg(REG_DEAD_TIME, dead);
      write_reg(REG_KEEPALIVE, ka);
      t = ($urandom_range(3) == 0) ? T_MAX - TW'($urandom_range(0, 200))
                                   : TW'({$urandom, $urandom});
      if (phase == 14) long_hold_go = 1'b1;

      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(99);
        if (n == 0 || pick < 8) begin
          cmd = CMD_REACTIVATE;
        end else if (pick < 84) begin
          cmd = CMD_CHECK;
          case ($urandom_range(3))
            0: t = t + TW'($urandom_range(0, 3));
            1: t = t + TW'(ka) + TW'($urandom_range(0, 2)) - TW'(1);  // around the deadline
            2: t = t + TW'($urandom_range(0, ka));
            default: t = t - TW'($urandom_range(0, 3));
          endcase
        end else begin
          // noise: arbitrary time, either command
          cmd = $urandom_range(1) ? CMD_REACTIVATE : CMD_CHECK;
          t   = TW'({$urandom, $urandom});
        end
        offer(cmd, t, 1'b0, '0);
        if (n == 25 && phase % 4 == 1) settle();
      end
    end

    settle();
    repeat (120) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("heartbeat_liveness_monitor regression: pass");
    end else begin
      $display("heartbeat_liveness_monitor regression: fail");
    end
    $finish;
  end

  // Watchdog on the run itself
  initial begin
    #5_000_000;
    $display("heartbeat_liveness_monitor regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/hlm_pkg.sv
design/hlm_if.sv
design/hlm_divider.sv
design/hlm_serial_alu.sv
design/heartbeat_liveness_monitor.sv
sim/heartbeat_liveness_monitor_tb.sv
